// File: rtl/core/fbsd_pkg.sv
// ----------------------------------------------------------------------------
// fbsd_pkg
// Shared types, codes and constants of the file bundle stream deframer.
// ----------------------------------------------------------------------------
package fbsd_pkg;

    // Input command codes
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Verdict codes
    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_BAD_MAGIC = 3'd1;
    localparam logic [2:0] VERDICT_BAD_COUNT = 3'd2;
    localparam logic [2:0] VERDICT_BAD_PLEN  = 3'd3;
    localparam logic [2:0] VERDICT_UNSAFE    = 3'd4;
    localparam logic [2:0] VERDICT_TOO_LARGE = 3'd5;
    localparam logic [2:0] VERDICT_TRUNCATED = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_FILES     = 2'd0;
    localparam logic [1:0] CFG_MAX_PATH_LEN  = 2'd1;
    localparam logic [1:0] CFG_MAX_FILE_SIZE = 2'd2;

    // Register reset values
    localparam logic [15:0] MAX_FILES_RST     = 16'd4096;
    localparam logic [15:0] MAX_PATH_LEN_RST  = 16'd4096;
    localparam logic [31:0] MAX_FILE_SIZE_RST = 32'd33554432;

    // Magic "I2DH", first byte first
    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h49, 8'h32, 8'h44, 8'h48};

    // Path characters and the "/.." window pattern
    localparam logic [7:0]  CHAR_SLASH     = 8'h2F;
    localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
    localparam logic [23:0] PAT_SLASH_DOTS = 24'h2F2E2E;

    // Result queue
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = 2;
    localparam int RES_CNT_W      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [15:0] file_index;
        logic        last_of_field;
        logic [2:0]  verdict;
    } result_t;

    function automatic result_t make_verdict(input logic [2:0] code,
                                             input logic [15:0] idx);
        result_t r;
        r.kind          = KIND_VERDICT;
        r.payload       = 8'd0;
        r.file_index    = idx;
        r.last_of_field = 1'b0;
        r.verdict       = code;
        return r;
    endfunction

    function automatic result_t make_byte(input logic [1:0] kind,
                                          input logic [7:0] b,
                                          input logic [15:0] idx,
                                          input logic last);
        result_t r;
        r.kind          = kind;
        r.payload       = b;
        r.file_index    = idx;
        r.last_of_field = last;
        r.verdict       = VERDICT_OK;
        return r;
    endfunction

endpackage

// File: rtl/core/fbsd_if.sv
// ----------------------------------------------------------------------------
// fbsd_if
// Valid/ready channel interfaces for stream items and result items.
// ----------------------------------------------------------------------------
interface fbsd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface fbsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [15:0] file_index;
    logic        last_of_field;
    logic [2:0]  verdict;

    modport source (output valid, output kind, output payload, output file_index,
                    output last_of_field, output verdict, input ready);
    modport sink   (input valid, input kind, input payload, input file_index,
                    input last_of_field, input verdict, output ready);
    modport monitor (input valid, input ready, input kind, input payload,
                     input file_index, input last_of_field, input verdict);
endinterface

// File: rtl/core/fbsd_result_fifo.sv
// ----------------------------------------------------------------------------
// fbsd_result_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module fbsd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  fbsd_pkg::result_t push0,
    input  fbsd_pkg::result_t push1,
    input  logic              pop,
    output fbsd_pkg::result_t rd_data,
    output logic              not_empty,
    output logic              has_room
);

    fbsd_pkg::result_t                   mem_reg [fbsd_pkg::RES_FIFO_DEPTH];
    logic [fbsd_pkg::RES_PTR_W-1:0]      head_reg, head_next;
    logic [fbsd_pkg::RES_PTR_W-1:0]      tail_reg, tail_next;
    logic [fbsd_pkg::RES_CNT_W-1:0]      count_reg, count_next;
    logic [fbsd_pkg::RES_PTR_W-1:0]      tail_plus1;

    assign tail_plus1 = fbsd_pkg::RES_PTR_W'(tail_reg + 1'b1);
    assign head_next  = pop ? fbsd_pkg::RES_PTR_W'(head_reg + 1'b1) : head_reg;
    assign tail_next  = fbsd_pkg::RES_PTR_W'(tail_reg + push_cnt);
    assign count_next = fbsd_pkg::RES_CNT_W'(count_reg
                        + fbsd_pkg::RES_CNT_W'(push_cnt)
                        - fbsd_pkg::RES_CNT_W'(pop));

    assign rd_data   = mem_reg[head_reg];
    assign not_empty = (count_reg != '0);
    // room for the two results one item can cause
    assign has_room  = (count_reg <= fbsd_pkg::RES_CNT_W'(fbsd_pkg::RES_FIFO_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[tail_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[tail_plus1] <= push1;
        end
    end

endmodule

// File: rtl/core/file_bundle_stream_deframer.sv
// ----------------------------------------------------------------------------
// file_bundle_stream_deframer
// Parses "I2DH" file bundles from a byte stream and forwards tagged bytes.
// ----------------------------------------------------------------------------
// Timing: results of an accepted item are registered in the result queue, and
//   out_ch is driven from the queue head; a second result is queued behind the first.
// Throughput: one item per cycle while out_ch drains; an item is handled by
//   combinational parser logic, and the 4-entry result queue sets back-pressure.
// Reset: rst_n clears the parser to idle, empties the result queue and
//   loads the limit registers with their defaults (4096, 4096, 32 MiB).
// ----------------------------------------------------------------------------
module file_bundle_stream_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    fbsd_in_if.sink     in_ch,
    fbsd_out_if.source  out_ch
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MAGIC,
        PH_COUNT,
        PH_PLEN,
        PH_PATH,
        PH_DLEN,
        PH_DATA,
        PH_DONE
    } phase_t;

    // Limit registers
    logic [15:0] max_files_reg;
    logic [15:0] max_path_len_reg;
    logic [31:0] max_file_size_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;          // byte position inside a 32-bit word
    logic [31:0] acc_reg, acc_next;          // little-endian word accumulator
    logic [15:0] files_rem_reg, files_rem_next;
    logic [15:0] cur_file_reg, cur_file_next;
    logic [31:0] bytes_rem_reg, bytes_rem_next;
    logic        path_first_reg, path_first_next;  // next path byte is the first
    logic [23:0] recent_reg, recent_next;    // last three path bytes
    logic        unsafe_reg, unsafe_next;

    // Per-item results
    logic [1:0]        res_cnt;
    fbsd_pkg::result_t res0, res1;

    logic              in_fire;
    logic              busy;
    logic [7:0]        b;
    logic [31:0]       word_full;     // word value once its fourth byte arrives
    logic              word_done;
    logic              last_byte;
    logic              unsafe_byte;
    logic [23:0]       recent_shift;

    logic              fifo_room;
    logic              fifo_not_empty;
    fbsd_pkg::result_t fifo_rd;

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign b            = in_ch.data_byte;
    assign busy         = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);
    assign word_full    = {b, acc_reg[23:0]};
    assign word_done    = (pos_reg == 2'd3);
    assign last_byte    = (bytes_rem_reg == 32'd1);
    assign recent_shift = {recent_reg[15:0], b};

    // Path hazards seen at this byte: leading '/', any '\', or "/../"
    assign unsafe_byte  = (path_first_reg && (b == fbsd_pkg::CHAR_SLASH))
                       || (b == fbsd_pkg::CHAR_BACKSLASH)
                       || ((b == fbsd_pkg::CHAR_SLASH)
                           && (recent_reg == fbsd_pkg::PAT_SLASH_DOTS));

    // ------------------------------------------------------------------
    // Configuration writes (index past the list is ignored)
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_files_reg     <= fbsd_pkg::MAX_FILES_RST;
            max_path_len_reg  <= fbsd_pkg::MAX_PATH_LEN_RST;
            max_file_size_reg <= fbsd_pkg::MAX_FILE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fbsd_pkg::CFG_MAX_FILES:     max_files_reg     <= cfg_wdata[15:0];
                fbsd_pkg::CFG_MAX_PATH_LEN:  max_path_len_reg  <= cfg_wdata[15:0];
                fbsd_pkg::CFG_MAX_FILE_SIZE: max_file_size_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser next state and results for the item on in_ch
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        files_rem_next  = files_rem_reg;
        cur_file_next   = cur_file_reg;
        bytes_rem_next  = bytes_rem_reg;
        path_first_next = path_first_reg;
        recent_next     = recent_reg;
        unsafe_next     = unsafe_reg;
        res_cnt         = 2'd0;
        res0            = fbsd_pkg::make_verdict(fbsd_pkg::VERDICT_OK, cur_file_reg);
        res1            = fbsd_pkg::make_verdict(fbsd_pkg::VERDICT_OK, cur_file_reg);

        if (in_fire)
        begin
            case (in_ch.cmd)
                fbsd_pkg::CMD_OPEN:
                begin
                    // abandon any bundle in flight, then restart
                    if (busy)
                    begin
                        res0    = fbsd_pkg::make_verdict(fbsd_pkg::VERDICT_TRUNCATED,
                                                         cur_file_reg);
                        res_cnt = 2'd1;
                    end
                    phase_next      = PH_MAGIC;
                    pos_next        = 2'd0;
                    acc_next        = 32'd0;
                    files_rem_next  = 16'd0;
                    cur_file_next   = 16'd0;
                    bytes_rem_next  = 32'd0;
                    path_first_next = 1'b1;
                    recent_next     = 24'd0;
                    unsafe_next     = 1'b0;
                end

                fbsd_pkg::CMD_CLOSE:
                begin
                    if (busy)
                    begin
                        res0    = fbsd_pkg::make_verdict(fbsd_pkg::VERDICT_TRUNCATED,
                                                         cur_file_reg);
                        res_cnt = 2'd1;
                    end
                    phase_next = PH_IDLE;
                end

                fbsd_pkg::CMD_DATA:
                begin
                    case (phase_reg)
                        PH_MAGIC:
                        begin
                            if (b != fbsd_pkg::MAGIC_BYTES[pos_reg])
                            begin
                                res0       = fbsd_pkg::make_verdict(
                                                 fbsd_pkg::VERDICT_BAD_MAGIC, cur_file_reg);
                                res_cnt    = 2'd1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                pos_next = 2'(pos_reg + 1'b1);
                                if (word_done)
                                begin
                                    phase_next = PH_COUNT;
                                    acc_next   = 32'd0;
                                end
                            end
                        end

                        PH_COUNT:
                        begin
                            pos_next = 2'(pos_reg + 1'b1);
                            acc_next = acc_reg | (32'(b) << {pos_reg, 3'b000});
                            if (word_done)
                            begin
                                if ((word_full == 32'd0)
                                    || (word_full > {16'd0, max_files_reg}))
                                begin
                                    res0       = fbsd_pkg::make_verdict(
                                                     fbsd_pkg::VERDICT_BAD_COUNT,
                                                     cur_file_reg);
                                    res_cnt    = 2'd1;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    files_rem_next = word_full[15:0];
                                    cur_file_next  = 16'd0;
                                    phase_next     = PH_PLEN;
                                    acc_next       = 32'd0;
                                end
                            end
                        end

                        PH_PLEN:
                        begin
                            pos_next = 2'(pos_reg + 1'b1);
                            acc_next = acc_reg | (32'(b) << {pos_reg, 3'b000});
                            if (word_done)
                            begin
                                if ((word_full == 32'd0)
                                    || (word_full > {16'd0, max_path_len_reg}))
                                begin
                                    res0       = fbsd_pkg::make_verdict(
                                                     fbsd_pkg::VERDICT_BAD_PLEN,
                                                     cur_file_reg);
                                    res_cnt    = 2'd1;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    // seed the window with '/' so a leading "../"
                                    // or a bare ".." match like "/../" and "/.."
                                    bytes_rem_next  = word_full;
                                    path_first_next = 1'b1;
                                    recent_next     = {16'd0, fbsd_pkg::CHAR_SLASH};
                                    unsafe_next     = 1'b0;
                                    phase_next      = PH_PATH;
                                end
                            end
                        end

                        PH_PATH:
                        begin
                            path_first_next = 1'b0;
                            recent_next     = recent_shift;
                            bytes_rem_next  = bytes_rem_reg - 32'd1;
                            unsafe_next     = unsafe_reg || unsafe_byte;
                            res0            = fbsd_pkg::make_byte(fbsd_pkg::KIND_PATH, b,
                                                                  cur_file_reg, last_byte);
                            res_cnt         = 2'd1;
                            if (last_byte)
                            begin
                                // trailing "/.." judged on the final window
                                if (unsafe_reg || unsafe_byte
                                    || (recent_shift == fbsd_pkg::PAT_SLASH_DOTS))
                                begin
                                    unsafe_next = 1'b1;
                                    res1        = fbsd_pkg::make_verdict(
                                                      fbsd_pkg::VERDICT_UNSAFE,
                                                      cur_file_reg);
                                    res_cnt     = 2'd2;
                                    phase_next  = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_DLEN;
                                    pos_next   = 2'd0;
                                    acc_next   = 32'd0;
                                end
                            end
                        end

                        PH_DLEN:
                        begin
                            pos_next = 2'(pos_reg + 1'b1);
                            acc_next = acc_reg | (32'(b) << {pos_reg, 3'b000});
                            if (word_done)
                            begin
                                if (word_full > max_file_size_reg)
                                begin
                                    res0       = fbsd_pkg::make_verdict(
                                                     fbsd_pkg::VERDICT_TOO_LARGE,
                                                     cur_file_reg);
                                    res_cnt    = 2'd1;
                                    phase_next = PH_DONE;
                                end
                                else if (word_full == 32'd0)
                                begin
                                    // empty file finishes right here
                                    files_rem_next = 16'(files_rem_reg - 1'b1);
                                    if (files_rem_reg == 16'd1)
                                    begin
                                        res0       = fbsd_pkg::make_verdict(
                                                         fbsd_pkg::VERDICT_OK,
                                                         cur_file_reg);
                                        res_cnt    = 2'd1;
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        cur_file_next = 16'(cur_file_reg + 1'b1);
                                        phase_next    = PH_PLEN;
                                        acc_next      = 32'd0;
                                    end
                                end
                                else
                                begin
                                    bytes_rem_next = word_full;
                                    phase_next     = PH_DATA;
                                end
                            end
                        end

                        PH_DATA:
                        begin
                            bytes_rem_next = bytes_rem_reg - 32'd1;
                            res0           = fbsd_pkg::make_byte(fbsd_pkg::KIND_CONTENT, b,
                                                                 cur_file_reg, last_byte);
                            res_cnt        = 2'd1;
                            if (last_byte)
                            begin
                                files_rem_next = 16'(files_rem_reg - 1'b1);
                                if (files_rem_reg == 16'd1)
                                begin
                                    res1       = fbsd_pkg::make_verdict(
                                                     fbsd_pkg::VERDICT_OK, cur_file_reg);
                                    res_cnt    = 2'd2;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    cur_file_next = 16'(cur_file_reg + 1'b1);
                                    phase_next    = PH_PLEN;
                                    pos_next      = 2'd0;
                                    acc_next      = 32'd0;
                                end
                            end
                        end

                        // idle or finished: data bytes are dropped
                        default: ;
                    endcase
                end

                // unused command code: no effect
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= 2'd0;
            acc_reg        <= 32'd0;
            files_rem_reg  <= 16'd0;
            cur_file_reg   <= 16'd0;
            bytes_rem_reg  <= 32'd0;
            path_first_reg <= 1'b1;
            recent_reg     <= 24'd0;
            unsafe_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
            files_rem_reg  <= files_rem_next;
            cur_file_reg   <= cur_file_next;
            bytes_rem_reg  <= bytes_rem_next;
            path_first_reg <= path_first_next;
            recent_reg     <= recent_next;
            unsafe_reg     <= unsafe_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: decouples the zero, one or two results per transfer
    // from the output channel, which takes one result per cycle while
    // out_ch.ready is high
    fbsd_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .pop       (out_ch.valid && out_ch.ready),
        .rd_data   (fifo_rd),
        .not_empty (fifo_not_empty),
        .has_room  (fifo_room)
    );

    assign in_ch.ready          = fifo_room;
    assign out_ch.valid         = fifo_not_empty;
    assign out_ch.kind          = fifo_rd.kind;
    assign out_ch.payload       = fifo_rd.payload;
    assign out_ch.file_index    = fifo_rd.file_index;
    assign out_ch.last_of_field = fifo_rd.last_of_field;
    assign out_ch.verdict       = fifo_rd.verdict;

endmodule

// File: rtl/core/fbsd_checker.sv
// ----------------------------------------------------------------------------
// fbsd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
module fbsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_payload,
    input logic       out_last,
    input logic [2:0] out_verdict
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == fbsd_pkg::KIND_PATH
                       || out_kind == fbsd_pkg::KIND_CONTENT
                       || out_kind == fbsd_pkg::KIND_VERDICT))
        else $error("illegal result kind");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == fbsd_pkg::KIND_VERDICT)
        |-> (out_payload == 8'd0 && !out_last))
        else $error("verdict carries byte fields");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != fbsd_pkg::KIND_VERDICT)
        |-> (out_verdict == fbsd_pkg::VERDICT_OK))
        else $error("byte result carries a verdict");

endmodule

bind file_bundle_stream_deframer fbsd_checker u_fbsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_payload (out_ch.payload),
    .out_last    (out_ch.last_of_field),
    .out_verdict (out_ch.verdict)
);
